// ===== sv/wide_divider_128_core_defines.svh =====
// Assertion macros for the wide divider RTL, used by wdv_step.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WIDE_DIVIDER_128_CORE_DEFINES_SVH
`define WIDE_DIVIDER_128_CORE_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define WDV_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define WDV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/wdv_pkg.sv =====
// Package for the wide divider: word widths and the per-stage payload type.
// No dependencies.
`default_nettype none
package wdv_pkg;
	localparam int unsigned W = 128;
	localparam int unsigned H = 64;

	typedef logic [W-1:0] word_t;

	// Payload carried from stage to stage of the division pipeline.
	// nq holds the dividend bits still to shift out in its top part and the
	// quotient bits already found in its bottom part.
	typedef struct packed {
		word_t nq;
		word_t z;
		word_t d;
		logic  sa;
		logic  sb;
	} step_t;
endpackage
`default_nettype wire

// ===== sv/wdv_prep.sv =====
// Input stage: takes operand magnitudes and records the operand signs.
// Depends on wdv_pkg.
`default_nettype none
module wdv_prep (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wdv_pkg::word_t dividend,
	input  wire wdv_pkg::word_t divisor,
	input  wire logic          signed_mode,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wdv_pkg::step_t     out_data
);
	logic           sa, sb;
	logic           valid_s1;
	wdv_pkg::step_t data_s1;

	// Signs only count in signed mode.
	assign sa = signed_mode & dividend[wdv_pkg::W-1];
	assign sb = signed_mode & divisor[wdv_pkg::W-1];

	assign in_ready  = !valid_s1 | out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// Valid bit of the stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Negation wraps modulo 2^128, so the most negative value stays as it is.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.nq <= sa ? (~dividend + wdv_pkg::W'(1)) : dividend;
			data_s1.d  <= sb ? (~divisor + wdv_pkg::W'(1)) : divisor;
			data_s1.z  <= '0;
			data_s1.sa <= sa;
			data_s1.sb <= sb;
		end
	end
endmodule
`default_nettype wire

// ===== sv/wdv_step.sv =====
// One restoring shift-subtract step of the division, with its stage register.
// Depends on wdv_pkg and wide_divider_128_core_defines.svh.
`default_nettype none
`include "wide_divider_128_core_defines.svh"
module wdv_step (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wdv_pkg::step_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wdv_pkg::step_t     out_data
);
	logic                 carry, take;
	wdv_pkg::word_t       zs;
	logic [wdv_pkg::W:0]  diff;
	logic                 valid_s1;
	wdv_pkg::step_t       data_s1;

	// Shift the next dividend bit into the partial remainder; the bit that
	// leaves its top forces a subtraction.
	assign carry = in_data.z[wdv_pkg::W-1];
	assign zs    = {in_data.z[wdv_pkg::W-2:0], in_data.nq[wdv_pkg::W-1]};
	assign diff  = {1'b0, zs} - {1'b0, in_data.d};
	assign take  = carry | !diff[wdv_pkg::W];

	assign in_ready  = !valid_s1 | out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// Valid bit of the stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Restore or keep the difference and append the quotient bit.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.z  <= take ? diff[wdv_pkg::W-1:0] : zs;
			data_s1.nq <= {in_data.nq[wdv_pkg::W-2:0], take};
			data_s1.d  <= in_data.d;
			data_s1.sa <= in_data.sa;
			data_s1.sb <= in_data.sb;
		end
	end

	`WDV_ASSERT(a_rem_below_div, valid_s1 && (data_s1.d != '0), data_s1.z < data_s1.d, "partial remainder not below divisor")
	`WDV_ASSERT_NEXT(a_hold_valid, valid_s1 && !out_ready, valid_s1, "stalled stage lost its beat")
	`WDV_ASSERT_NEXT(a_hold_data, valid_s1 && !out_ready, $stable(data_s1), "stalled stage changed its beat")
endmodule
`default_nettype wire

// ===== sv/wdv_fixup.sv =====
// Output stage: applies floor rounding and signs, and holds the result beat.
// Depends on wdv_pkg.
`default_nettype none
module wdv_fixup (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wdv_pkg::step_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wdv_pkg::word_t     quotient,
	output wdv_pkg::word_t     remainder
);
	wdv_pkg::word_t q, r, q_res, r_res;
	logic           valid_s1;
	wdv_pkg::word_t q_s1, r_s1;

	assign q = in_data.nq;
	assign r = in_data.z;

	// Signs differ: negate an exact quotient, otherwise round down and move
	// the remainder to the divisor's side. Both negative: negate remainder.
	always_comb begin
		q_res = q;
		r_res = r;
		if (in_data.sa != in_data.sb) begin
			if (r == '0) begin
				q_res = ~q + wdv_pkg::W'(1);
			end else begin
				q_res = ~q;
				r_res = in_data.sb ? (r - in_data.d) : (in_data.d - r);
			end
		end else if (in_data.sb) begin
			r_res = ~r + wdv_pkg::W'(1);
		end
	end

	assign in_ready  = !valid_s1 | out_ready;
	assign out_valid = valid_s1;
	assign quotient  = q_s1;
	assign remainder = r_s1;

	// Valid bit of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_s1 <= q_res;
			r_s1 <= r_res;
		end
	end
endmodule
`default_nettype wire

// ===== sv/wide_divider_128_core.sv =====
// 128-bit restoring divider, unsigned or signed with floor rounding.
//
// Input channel s_*: one beat carries dividend and divisor in s_tdata and the
// signed-mode flag in s_tuser. Output channel m_*: one beat carries quotient
// and remainder in m_tdata. Every input beat gives exactly one output beat,
// in order.
// From acceptance to m_tvalid a beat passes these stages: one stage forms the
// operand magnitudes, 128 stages each do one shift-subtract step (one 129-bit
// subtract and select), and one stage applies the signs and floor rounding.
// Throughput is one beat per cycle while the receiver does not stall.
// Each stage has its own valid bit and accepts a beat when it is empty or
// its beat moves on, so bubbles close up. When the receiver stalls, results
// stay held and the pipeline keeps filling until every stage is full; then
// s_tready drops. Nothing is lost or repeated.
// A zero divisor gives the dividend as the remainder and an all-ones quotient
// (zero for a signed negative dividend). Reset empties all stages; no beat is
// in flight afterwards. Depends on wdv_pkg, wdv_prep, wdv_step and wdv_fixup.
`default_nettype none
module wide_divider_128_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// dividend_high, dividend_low, divisor_high, divisor_low
	input  wire logic [255:0] s_tdata,
	// signed_mode
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// quotient_high, quotient_low, remainder_high, remainder_low
	output logic [255:0]      m_tdata
);
	localparam int unsigned N = wdv_pkg::W;

	logic           valid  [N+1];
	logic           ready  [N+1];
	wdv_pkg::step_t data   [N+1];
	wdv_pkg::word_t quotient, remainder;

	// Operand preparation.
	wdv_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.dividend    ({s_tdata[63:0], s_tdata[127:64]}),
		.divisor     ({s_tdata[191:128], s_tdata[255:192]}),
		.signed_mode (s_tuser[0]),
		.out_valid   (valid[0]),
		.out_ready   (ready[0]),
		.out_data    (data[0])
	);

	// One stage per quotient bit.
	for (genvar i = 0; i < N; i++) begin : g_step
		wdv_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_data   (data[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_data  (data[i+1])
		);
	end

	// Sign correction and output register.
	wdv_fixup u_fixup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid[N]),
		.in_ready  (ready[N]),
		.in_data   (data[N]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign m_tdata = {remainder[wdv_pkg::H-1:0], remainder[wdv_pkg::W-1:wdv_pkg::H],
	                  quotient[wdv_pkg::H-1:0], quotient[wdv_pkg::W-1:wdv_pkg::H]};
endmodule
`default_nettype wire

// ===== tb/tb_wide_divider_128_core.sv =====
// Self-checking testbench for wide_divider_128_core: 128-bit restoring divider.
// Predicts quotient and remainder per beat and checks them against the output stream.
// Depends on the RTL only (wdv_pkg and the core with its submodules).
`default_nettype none
module tb_wide_divider_128_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [127:0] quo;
		logic [127:0] rem;
	} div_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [255:0] m_tdata;

	div_result_t  pending_results[$];
	int           error_count;
	int           sent_count;
	int           recv_count;
	int           idle_cycles;
	int           send_idle_pct;
	int           recv_stall_pct;

	localparam int WATCHDOG_LIMIT = 5000;

	wide_divider_128_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Floor division on two's complement operands, or plain unsigned division.
	function automatic div_result_t divide_floor(logic [127:0] num, logic [127:0] den,
		logic is_signed);
		div_result_t  res;
		logic         neg_num;
		logic         neg_den;
		logic [127:0] mag_num;
		logic [127:0] mag_den;
		logic [127:0] q;
		logic [127:0] r;
		neg_num = is_signed & num[127];
		neg_den = is_signed & den[127];
		mag_num = neg_num ? -num : num;
		mag_den = neg_den ? -den : den;
		if (mag_den == '0) begin
			q = '1;
			r = mag_num;
		end else begin
			q = mag_num / mag_den;
			r = mag_num % mag_den;
		end
		if (neg_num != neg_den) begin
			if (r == '0) begin
				q = -q;
			end else begin
				q = ~q;
				r = neg_den ? r - mag_den : mag_den - r;
			end
		end else if (neg_den) begin
			r = -r;
		end
		res.quo = q;
		res.rem = r;
		return res;
	endfunction

	// Sends one beat, idling at random first, and records its expected result.
	// The valid line stays high after the beat so that a following beat can
	// go out in the next cycle; idling or waiting for the drain lowers it.
	task automatic send_division(logic [127:0] num, logic [127:0] den, logic is_signed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {den[63:0], den[127:64], num[63:0], num[127:64]};
		s_tuser  <= is_signed;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(divide_floor(num, den, is_signed));
		sent_count++;
		@(negedge clk);
	endtask

	// Receiver stalls at random.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compares each output beat with the oldest expected result.
	always @(posedge clk) begin
		div_result_t exp_res;
		logic [127:0] got_quo;
		logic [127:0] got_rem;
		if (arst_n && m_tvalid && m_tready) begin
			got_quo = {m_tdata[63:0], m_tdata[127:64]};
			got_rem = {m_tdata[191:128], m_tdata[255:192]};
			recv_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result quo=%h rem=%h", $time, got_quo, got_rem);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (got_quo !== exp_res.quo) begin
					$display("%0t: quotient expected %h actual %h", $time,
						exp_res.quo, got_quo);
					error_count++;
				end
				if (got_rem !== exp_res.rem) begin
					$display("%0t: remainder expected %h actual %h", $time,
						exp_res.rem, got_rem);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("tb_wide_divider_128_core: errors");
			$finish;
		end
	end

	// Random 128-bit operand, often narrow so that quotients vary in size.
	function automatic logic [127:0] random_operand();
		logic [127:0] v;
		int           keep;
		v = {$urandom, $urandom, $urandom, $urandom};
		keep = $urandom_range(128, 1);
		if ($urandom_range(1)) v = v >> (128 - keep);
		if ($urandom_range(7) == 0) v = -v;
		return v;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Zero divisor, extremes and the most negative operand.
	task automatic test_corner_cases();
		logic [127:0] most_neg;
		most_neg = {1'b1, 127'b0};
		for (int m = 0; m < 2; m++) begin
			send_division(128'd12345, '0, 1'(m));
			send_division(-128'd12345, '0, 1'(m));
			send_division('1, 128'd1, 1'(m));
			send_division('1, '1, 1'(m));
			send_division(most_neg, '1, 1'(m));
			send_division(most_neg, 128'd1, 1'(m));
			send_division(128'd7, most_neg, 1'(m));
			send_division('0, 128'd3, 1'(m));
			send_division(-128'd7, 128'd2, 1'(m));
			send_division(128'd7, -128'd2, 1'(m));
			send_division(-128'd7, -128'd2, 1'(m));
			send_division(-128'd6, 128'd3, 1'(m));
		end
	endtask

	task automatic test_random_divisions(int count);
		for (int i = 0; i < count; i++)
			send_division(random_operand(), random_operand(), 1'($urandom_range(1)));
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic test_drain_pause();
		wait_drained();
		test_random_divisions(20);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		error_count = 0;
		sent_count = 0;
		recv_count = 0;
		idle_cycles = 0;
		send_idle_pct = 21;
		recv_stall_pct = 56;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_cases();
		test_random_divisions(360);
		test_drain_pause();
		send_idle_pct = 56;
		recv_stall_pct = 21;
		test_random_divisions(380);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_divisions(380);

		wait_drained();
		repeat (140) @(negedge clk);
		$display("Ran %0d divisions (%0d results): zero divisors, signed extremes,",
			sent_count, recv_count);
		$display("random widths and signs under three idling patterns.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("tb_wide_divider_128_core: clean");
		end else begin
			$display("tb_wide_divider_128_core: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
